// File: rtl/core/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// shared widths, constants, sector codes and stage payload types of the
// hsv to rgb pixel converter
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	localparam int HUE_W       = 13;
	localparam int CH_W        = 8;
	localparam int FRAC_W      = 10;
	localparam int NUM_W       = 18;
	localparam int PROD_W      = 26;
	localparam int RECIP_W     = 27;
	localparam int RECIP_SHIFT = 44;
	localparam int SCALED_W    = PROD_W + RECIP_W;

	localparam logic [HUE_W-1:0]  SECTOR_SPAN = 13'd960;
	localparam logic [HUE_W-1:0]  HUE_TURN    = 13'd5760;
	localparam logic [CH_W-1:0]   UNIT        = 8'd255;
	localparam logic [NUM_W-1:0]  FULL_SCALE  = 18'd244800;

	// ceil(2^44 / 244800): exact floor division for every 26-bit numerator
	localparam longint unsigned RECIP_EXACT =
		((64'd1 << RECIP_SHIFT) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_EXACT);

	typedef enum logic [2:0] {
		SEC_R_TO_Y = 3'd0,
		SEC_Y_TO_G = 3'd1,
		SEC_G_TO_C = 3'd2,
		SEC_C_TO_B = 3'd3,
		SEC_B_TO_M = 3'd4,
		SEC_M_TO_R = 3'd5
	} sector_t;

	typedef struct packed {
		sector_t           sector;
		logic [FRAC_W-1:0] frac;
		logic [CH_W-1:0]   sat;
		logic [CH_W-1:0]   val;
	} split_t;

	typedef struct packed {
		sector_t          sector;
		logic [CH_W-1:0]  val;
		logic [NUM_W-1:0] num_p;
		logic [NUM_W-1:0] num_q;
		logic [NUM_W-1:0] num_t;
	} num_t;

	typedef struct packed {
		sector_t           sector;
		logic [CH_W-1:0]   val;
		logic [PROD_W-1:0] prod_p;
		logic [PROD_W-1:0] prod_q;
		logic [PROD_W-1:0] prod_t;
	} prod_t;

	typedef struct packed {
		sector_t         sector;
		logic [CH_W-1:0] val;
		logic [CH_W-1:0] chan_p;
		logic [CH_W-1:0] chan_q;
		logic [CH_W-1:0] chan_t;
	} chan_t;

endpackage

// File: rtl/core/hsv2rgb_sector.sv
// ----------------------------------------------------------------------------
// hsv2rgb_sector
// first stage: wraps the hue into one turn and splits it into sector and
// fraction within the sector
// ----------------------------------------------------------------------------
module hsv2rgb_sector (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [hsv2rgb_pkg::HUE_W-1:0]  hue,
	input  logic [hsv2rgb_pkg::CH_W-1:0]   saturation,
	input  logic [hsv2rgb_pkg::CH_W-1:0]   brightness,
	output logic                           out_valid,
	input  logic                           out_ready,
	output hsv2rgb_pkg::split_t            out_data
);

	logic [hsv2rgb_pkg::HUE_W-1:0] hue_wrap;
	logic [hsv2rgb_pkg::HUE_W-1:0] base;
	logic [hsv2rgb_pkg::HUE_W-1:0] offset;
	hsv2rgb_pkg::sector_t          sector;
	logic                          valid_s1;
	hsv2rgb_pkg::split_t           data_s1;

	always_comb begin
		hue_wrap = hue;
		if (hue >= hsv2rgb_pkg::HUE_TURN) begin
			hue_wrap = hue - hsv2rgb_pkg::HUE_TURN;
		end
		priority if (hue_wrap >= hsv2rgb_pkg::SECTOR_SPAN * 13'd5) begin
			sector = hsv2rgb_pkg::SEC_M_TO_R;
			base   = hsv2rgb_pkg::SECTOR_SPAN * 13'd5;
		end else if (hue_wrap >= hsv2rgb_pkg::SECTOR_SPAN * 13'd4) begin
			sector = hsv2rgb_pkg::SEC_B_TO_M;
			base   = hsv2rgb_pkg::SECTOR_SPAN * 13'd4;
		end else if (hue_wrap >= hsv2rgb_pkg::SECTOR_SPAN * 13'd3) begin
			sector = hsv2rgb_pkg::SEC_C_TO_B;
			base   = hsv2rgb_pkg::SECTOR_SPAN * 13'd3;
		end else if (hue_wrap >= hsv2rgb_pkg::SECTOR_SPAN * 13'd2) begin
			sector = hsv2rgb_pkg::SEC_G_TO_C;
			base   = hsv2rgb_pkg::SECTOR_SPAN * 13'd2;
		end else if (hue_wrap >= hsv2rgb_pkg::SECTOR_SPAN) begin
			sector = hsv2rgb_pkg::SEC_Y_TO_G;
			base   = hsv2rgb_pkg::SECTOR_SPAN;
		end else begin
			sector = hsv2rgb_pkg::SEC_R_TO_Y;
			base   = '0;
		end
		offset = hue_wrap - base;
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1.sector <= sector;
			data_s1.frac   <= offset[hsv2rgb_pkg::FRAC_W-1:0];
			data_s1.sat    <= saturation;
			data_s1.val    <= brightness;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// File: rtl/core/hsv2rgb_terms.sv
// ----------------------------------------------------------------------------
// hsv2rgb_terms
// second and third stages: numerators of p, q and t over the full scale,
// then their products with the value channel
// ----------------------------------------------------------------------------
module hsv2rgb_terms (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hsv2rgb_pkg::split_t in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output hsv2rgb_pkg::prod_t  out_data
);

	logic [hsv2rgb_pkg::NUM_W-1:0]  sat_frac;
	logic [hsv2rgb_pkg::NUM_W-1:0]  sat_rest;
	logic [hsv2rgb_pkg::FRAC_W-1:0] rest;
	logic [hsv2rgb_pkg::NUM_W-1:0]  num_p;
	logic                           valid_s2;
	hsv2rgb_pkg::num_t              data_s2;
	logic                           ready_s2;
	logic                           valid_s3;
	hsv2rgb_pkg::prod_t             data_s3;

	// s*f, s*(960-f) and (255-s)*960, all over 255*960
	always_comb begin
		rest     = hsv2rgb_pkg::SECTOR_SPAN[hsv2rgb_pkg::FRAC_W-1:0] - in_data.frac;
		sat_frac = hsv2rgb_pkg::NUM_W'(in_data.sat) * hsv2rgb_pkg::NUM_W'(in_data.frac);
		sat_rest = hsv2rgb_pkg::NUM_W'(in_data.sat) * hsv2rgb_pkg::NUM_W'(rest);
		num_p    = hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::UNIT - in_data.sat)
			* hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::SECTOR_SPAN);
	end

	assign in_ready = !valid_s2 || ready_s2;
	assign ready_s2 = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s2 <= in_valid;
			end
			if (ready_s2) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2.sector <= in_data.sector;
			data_s2.val    <= in_data.val;
			data_s2.num_p  <= num_p;
			data_s2.num_q  <= hsv2rgb_pkg::FULL_SCALE - sat_frac;
			data_s2.num_t  <= hsv2rgb_pkg::FULL_SCALE - sat_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s2) begin
			data_s3.sector <= data_s2.sector;
			data_s3.val    <= data_s2.val;
			data_s3.prod_p <= hsv2rgb_pkg::PROD_W'(data_s2.val)
				* hsv2rgb_pkg::PROD_W'(data_s2.num_p);
			data_s3.prod_q <= hsv2rgb_pkg::PROD_W'(data_s2.val)
				* hsv2rgb_pkg::PROD_W'(data_s2.num_q);
			data_s3.prod_t <= hsv2rgb_pkg::PROD_W'(data_s2.val)
				* hsv2rgb_pkg::PROD_W'(data_s2.num_t);
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

// File: rtl/core/hsv2rgb_scale.sv
// ----------------------------------------------------------------------------
// hsv2rgb_scale
// fourth stage: divides each product by 255*960 through an exact
// reciprocal multiply and keeps the truncated channel value
// ----------------------------------------------------------------------------
module hsv2rgb_scale (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  hsv2rgb_pkg::prod_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output hsv2rgb_pkg::chan_t out_data
);

	logic [hsv2rgb_pkg::SCALED_W-1:0] scaled_p;
	logic [hsv2rgb_pkg::SCALED_W-1:0] scaled_q;
	logic [hsv2rgb_pkg::SCALED_W-1:0] scaled_t;
	logic                             valid_s4;
	hsv2rgb_pkg::chan_t               data_s4;

	always_comb begin
		scaled_p = hsv2rgb_pkg::SCALED_W'(in_data.prod_p)
			* hsv2rgb_pkg::SCALED_W'(hsv2rgb_pkg::RECIP);
		scaled_q = hsv2rgb_pkg::SCALED_W'(in_data.prod_q)
			* hsv2rgb_pkg::SCALED_W'(hsv2rgb_pkg::RECIP);
		scaled_t = hsv2rgb_pkg::SCALED_W'(in_data.prod_t)
			* hsv2rgb_pkg::SCALED_W'(hsv2rgb_pkg::RECIP);
	end

	assign in_ready = !valid_s4 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (in_ready) begin
			valid_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s4.sector <= in_data.sector;
			data_s4.val    <= in_data.val;
			data_s4.chan_p <= scaled_p[hsv2rgb_pkg::RECIP_SHIFT +: hsv2rgb_pkg::CH_W];
			data_s4.chan_q <= scaled_q[hsv2rgb_pkg::RECIP_SHIFT +: hsv2rgb_pkg::CH_W];
			data_s4.chan_t <= scaled_t[hsv2rgb_pkg::RECIP_SHIFT +: hsv2rgb_pkg::CH_W];
		end
	end

	assign out_valid = valid_s4;
	assign out_data  = data_s4;

endmodule

// File: rtl/core/hsv_to_rgb_converter_top.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// hsv pixel in, rgb pixel out, five register stages
//
// input channel: in_valid / in_ready carry one hsv beat (hue in sixteenths
//   of a degree, saturation and brightness as 8-bit fractions of one)
// output channel: out_valid / out_ready carry one rgb beat per input beat,
//   in the order the inputs were taken
// depth: a beat taken at the input passes in order through the sector split,
//   the numerator multipliers, the value multipliers, the reciprocal divide
//   by 255*960 and the output register
// throughput: one beat per cycle while out_ready stays high
// reset: arst_n empties every stage at once; in_ready is high straight away
// stall: with out_ready low the result holds at the output; each stage
//   keeps taking beats until it is full, so bubbles close up and nothing
//   is dropped or repeated
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [hsv2rgb_pkg::HUE_W-1:0] hue,
	input  logic [hsv2rgb_pkg::CH_W-1:0]  saturation,
	input  logic [hsv2rgb_pkg::CH_W-1:0]  brightness,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [hsv2rgb_pkg::CH_W-1:0]  red,
	output logic [hsv2rgb_pkg::CH_W-1:0]  green,
	output logic [hsv2rgb_pkg::CH_W-1:0]  blue
);

	logic                          split_valid;
	logic                          split_ready;
	hsv2rgb_pkg::split_t           split_data;
	logic                          prod_valid;
	logic                          prod_ready;
	hsv2rgb_pkg::prod_t            prod_data;
	logic                          chan_valid;
	logic                          chan_ready;
	hsv2rgb_pkg::chan_t            chan_data;
	logic [hsv2rgb_pkg::CH_W-1:0]  red_mux;
	logic [hsv2rgb_pkg::CH_W-1:0]  green_mux;
	logic [hsv2rgb_pkg::CH_W-1:0]  blue_mux;
	logic                          valid_s5;
	logic [hsv2rgb_pkg::CH_W-1:0]  red_s5;
	logic [hsv2rgb_pkg::CH_W-1:0]  green_s5;
	logic [hsv2rgb_pkg::CH_W-1:0]  blue_s5;

	hsv2rgb_sector u_sector (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.out_valid  (split_valid),
		.out_ready  (split_ready),
		.out_data   (split_data)
	);

	hsv2rgb_terms u_terms (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (split_valid),
		.in_ready  (split_ready),
		.in_data   (split_data),
		.out_valid (prod_valid),
		.out_ready (prod_ready),
		.out_data  (prod_data)
	);

	hsv2rgb_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prod_valid),
		.in_ready  (prod_ready),
		.in_data   (prod_data),
		.out_valid (chan_valid),
		.out_ready (chan_ready),
		.out_data  (chan_data)
	);

	// channel order per sector
	always_comb begin
		unique case (chan_data.sector)
			hsv2rgb_pkg::SEC_R_TO_Y: begin
				red_mux   = chan_data.val;
				green_mux = chan_data.chan_t;
				blue_mux  = chan_data.chan_p;
			end
			hsv2rgb_pkg::SEC_Y_TO_G: begin
				red_mux   = chan_data.chan_q;
				green_mux = chan_data.val;
				blue_mux  = chan_data.chan_p;
			end
			hsv2rgb_pkg::SEC_G_TO_C: begin
				red_mux   = chan_data.chan_p;
				green_mux = chan_data.val;
				blue_mux  = chan_data.chan_t;
			end
			hsv2rgb_pkg::SEC_C_TO_B: begin
				red_mux   = chan_data.chan_p;
				green_mux = chan_data.chan_q;
				blue_mux  = chan_data.val;
			end
			hsv2rgb_pkg::SEC_B_TO_M: begin
				red_mux   = chan_data.chan_t;
				green_mux = chan_data.chan_p;
				blue_mux  = chan_data.val;
			end
			default: begin
				red_mux   = chan_data.val;
				green_mux = chan_data.chan_p;
				blue_mux  = chan_data.chan_q;
			end
		endcase
	end

	assign chan_ready = !valid_s5 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (chan_ready) begin
			valid_s5 <= chan_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chan_ready && chan_valid) begin
			red_s5   <= red_mux;
			green_s5 <= green_mux;
			blue_s5  <= blue_mux;
		end
	end

	assign out_valid = valid_s5;
	assign red       = red_s5;
	assign green     = green_s5;
	assign blue      = blue_s5;

endmodule

// File: rtl/core/hsv2rgb_checker.sv
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// port-level checks of the converter, bound to the top level
// ----------------------------------------------------------------------------
module hsv2rgb_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [hsv2rgb_pkg::HUE_W-1:0] hue,
	input logic [hsv2rgb_pkg::CH_W-1:0]  saturation,
	input logic [hsv2rgb_pkg::CH_W-1:0]  brightness,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [hsv2rgb_pkg::CH_W-1:0]  red,
	input logic [hsv2rgb_pkg::CH_W-1:0]  green,
	input logic [hsv2rgb_pkg::CH_W-1:0]  blue
);

	// waiting input beat stays, payload unchanged
	a_in_stable: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(hue) && $stable(saturation)
			&& $stable(brightness))
		else $error("input beat changed while waiting");

	// stalled output beat stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped while stalled");

	// stalled output payload stays
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(red) && $stable(green) && $stable(blue))
		else $error("output payload changed while stalled");

	// reset empties the pipe
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output beat present straight after reset");

	// a free output end means the whole pipe can move
	a_no_bubble_stall: assert property (@(posedge clk)
		out_ready || !out_valid |-> in_ready)
		else $error("input stalled although the output end is free");

endmodule

bind hsv_to_rgb_converter_top hsv2rgb_checker u_hsv2rgb_checker (.*);
